FILE: hdl/pmt_pkg.sv
// Shared types and constants for the PMT section parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pmt_pkg;

    localparam int PacketBytesDefault = 188;
    localparam int QueueDepth         = 4;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PID   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROGRAM_SLOT = 1'd1;

    localparam int OUT_TDATA_W = 40;

    // One elementary-stream entry as it travels from the parser to the output.
    typedef struct packed {
        logic [7:0]  slot_echo;
        logic [5:0]  entry_index;
        logic [7:0]  stream_kind;
        logic [12:0] es_pid;
        logic        last_entry;
    } pmt_entry_t;

endpackage

FILE: hdl/pmt_parse_front.sv
// Byte parser: holds the configuration registers, tracks the packet header
// and walks the elementary-stream loop. Depends on pmt_pkg.
`timescale 1ns / 1ps

module pmt_parse_front
    import pmt_pkg::*;
#(
    parameter int PACKET_BYTES = PacketBytesDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   byte_fire,
    input  logic [7:0]             byte_value,
    input  logic                   packet_start,
    output logic                   entry_push,
    output pmt_entry_t             entry
);

    localparam logic [7:0] SYNC_BYTE = 8'h47;

    localparam logic [7:0] POS_SYNC    = 8'd0;
    localparam logic [7:0] POS_PID_HI  = 8'd1;
    localparam logic [7:0] POS_PID_LO  = 8'd2;
    localparam logic [7:0] POS_SEC_HI  = 8'd6;
    localparam logic [7:0] POS_SEC_LO  = 8'd7;
    localparam logic [7:0] POS_INFO_HI = 8'd15;
    localparam logic [7:0] POS_INFO_LO = 8'd16;
    localparam logic [7:0] LOOP_START  = 8'd17;

    localparam logic [12:0] SECTION_OVERHEAD = 13'd13;
    localparam logic [12:0] ENTRY_FIXED      = 13'd5;

    localparam logic [12:0] ENT_TYPE     = 13'd0;
    localparam logic [12:0] ENT_PID_HI   = 13'd1;
    localparam logic [12:0] ENT_PID_LO   = 13'd2;
    localparam logic [12:0] ENT_INFO_HI  = 13'd3;
    localparam logic [12:0] ENT_INFO_LO  = 13'd4;

    logic [12:0] target_pid_reg;
    logic [7:0]  program_slot_reg;

    logic [7:0]  byte_position_reg,    byte_position_next;
    logic        packet_accepted_reg,  packet_accepted_next;
    logic [4:0]  pid_high_bits_reg,    pid_high_bits_next;
    logic [11:0] section_len_reg,      section_len_next;
    logic [11:0] info_len_reg,         info_len_next;
    logic [13:0] remaining_bytes_reg,  remaining_bytes_next;
    logic [12:0] next_entry_start_reg, next_entry_start_next;
    logic [7:0]  held_type_reg,        held_type_next;
    logic [12:0] held_pid_reg,         held_pid_next;
    logic [3:0]  held_esinfo_high_reg, held_esinfo_high_next;
    logic [5:0]  entry_count_reg,      entry_count_next;

    logic [7:0]  pos;
    logic [11:0] info_full;
    logic [12:0] loop_overhead;
    logic [12:0] entry_offset;
    logic [12:0] step;
    logic        last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pid_reg   <= '0;
            program_slot_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TARGET_PID:   target_pid_reg   <= cfg_data;
                CFG_PROGRAM_SLOT: program_slot_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        pos           = packet_start ? POS_SYNC : byte_position_reg;
        info_full     = {info_len_reg[11:8], byte_value};
        loop_overhead = SECTION_OVERHEAD + {1'b0, info_full};
        entry_offset  = {5'd0, pos} - next_entry_start_reg;
        step          = ENTRY_FIXED + {1'b0, held_esinfo_high_reg, byte_value};
        last          = remaining_bytes_reg <= {1'b0, step};

        byte_position_next    = byte_position_reg;
        packet_accepted_next  = packet_accepted_reg;
        pid_high_bits_next    = pid_high_bits_reg;
        section_len_next      = section_len_reg;
        info_len_next         = info_len_reg;
        remaining_bytes_next  = remaining_bytes_reg;
        next_entry_start_next = next_entry_start_reg;
        held_type_next        = held_type_reg;
        held_pid_next         = held_pid_reg;
        held_esinfo_high_next = held_esinfo_high_reg;
        entry_count_next      = entry_count_reg;
        entry_push            = 1'b0;

        entry.slot_echo   = program_slot_reg;
        entry.entry_index = entry_count_reg;
        entry.stream_kind = held_type_reg;
        entry.es_pid      = held_pid_reg;
        entry.last_entry  = last;

        // Bytes past the packet end are taken and dropped.
        if (byte_fire && pos < 8'(PACKET_BYTES))
        begin
            byte_position_next = pos + 8'd1;
            case (pos)
                POS_SYNC:
                begin
                    packet_accepted_next  = (byte_value == SYNC_BYTE);
                    remaining_bytes_next  = '0;
                    next_entry_start_next = '0;
                    entry_count_next      = '0;
                end
                POS_PID_HI:
                    pid_high_bits_next = byte_value[4:0];
                POS_PID_LO:
                begin
                    if ({pid_high_bits_reg, byte_value} != target_pid_reg)
                        packet_accepted_next = 1'b0;
                end
                POS_SEC_HI:
                    section_len_next = {byte_value[3:0], 8'h00};
                POS_SEC_LO:
                    section_len_next = {section_len_reg[11:8], byte_value};
                POS_INFO_HI:
                    info_len_next = {byte_value[3:0], 8'h00};
                POS_INFO_LO:
                begin
                    info_len_next         = info_full;
                    next_entry_start_next = {5'd0, LOOP_START} + {1'b0, info_full};
                    if ({1'b0, section_len_reg} > loop_overhead)
                        remaining_bytes_next = {2'b00, section_len_reg} - {1'b0, loop_overhead};
                    else
                        remaining_bytes_next = '0;
                end
                default:
                begin
                    if (packet_accepted_reg && pos >= LOOP_START &&
                        remaining_bytes_reg != '0 &&
                        {5'd0, pos} >= next_entry_start_reg)
                    begin
                        case (entry_offset)
                            ENT_TYPE:    held_type_next = byte_value;
                            ENT_PID_HI:  held_pid_next  = {byte_value[4:0], 8'h00};
                            ENT_PID_LO:  held_pid_next  = {held_pid_reg[12:8], byte_value};
                            ENT_INFO_HI: held_esinfo_high_next = byte_value[3:0];
                            ENT_INFO_LO:
                            begin
                                entry_push            = 1'b1;
                                remaining_bytes_next  = last ? '0
                                                             : remaining_bytes_reg - {1'b0, step};
                                next_entry_start_next = next_entry_start_reg + step;
                                entry_count_next      = entry_count_reg + 6'd1;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= '0;
            packet_accepted_reg  <= 1'b0;
            pid_high_bits_reg    <= '0;
            section_len_reg      <= '0;
            info_len_reg         <= '0;
            remaining_bytes_reg  <= '0;
            next_entry_start_reg <= '0;
            held_type_reg        <= '0;
            held_pid_reg         <= '0;
            held_esinfo_high_reg <= '0;
            entry_count_reg      <= '0;
        end
        else
        begin
            byte_position_reg    <= byte_position_next;
            packet_accepted_reg  <= packet_accepted_next;
            pid_high_bits_reg    <= pid_high_bits_next;
            section_len_reg      <= section_len_next;
            info_len_reg         <= info_len_next;
            remaining_bytes_reg  <= remaining_bytes_next;
            next_entry_start_reg <= next_entry_start_next;
            held_type_reg        <= held_type_next;
            held_pid_reg         <= held_pid_next;
            held_esinfo_high_reg <= held_esinfo_high_next;
            entry_count_reg      <= entry_count_next;
        end
    end

endmodule

FILE: hdl/pmt_entry_fifo.sv
// Short register queue of parsed entries between parser and output stage.
// Depends on pmt_pkg.
`timescale 1ns / 1ps

module pmt_entry_fifo
    import pmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pmt_entry_t push_data,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output pmt_entry_t head
);

    localparam int PTR_W = $clog2(QueueDepth);
    localparam int CNT_W = $clog2(QueueDepth + 1);

    pmt_entry_t             slots_reg [QueueDepth];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/pmt_out_stage.sv
// Output register: takes entries from the queue and presents them on the
// master stream. Depends on pmt_pkg.
`timescale 1ns / 1ps

module pmt_out_stage
    import pmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   queue_not_empty,
    input  pmt_entry_t             queue_head,
    output logic                   queue_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic       out_valid_reg;
    pmt_entry_t out_data_reg;

    // Refill whenever the register is empty or its transaction completes now.
    assign queue_pop = queue_not_empty && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (queue_pop)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (queue_pop)
            out_data_reg <= queue_head;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.last_entry;
    assign m_tdata  = {5'd0, out_data_reg.es_pid, out_data_reg.stream_kind,
                       out_data_reg.entry_index, out_data_reg.slot_echo};

endmodule

FILE: hdl/pmt_section_parser.sv
// Top level of the PMT section parser: parser front, entry queue, output stage.
// Depends on pmt_pkg, pmt_parse_front, pmt_entry_fifo and pmt_out_stage.
//
//   Port group   Dir  Carries
//   s_*          in   one transport packet byte per transaction, tuser = packet start
//   m_*          out  one elementary-stream entry per transaction, tlast = last entry
//   cfg_*        in   register writes: 0 target PID, 1 program slot
//
// One byte is taken per cycle while the queue is not full; an entry is queued in
// the same cycle as its fifth byte and reaches m_* through the queue and the output register.
// s_tready drops only while the four-entry queue is full.
// Reset is asynchronous and clears registers, packet state and queue.
// Output stalls back up through the queue into the byte input.
`timescale 1ns / 1ps

module pmt_section_parser
    import pmt_pkg::*;
#(
    parameter int PACKET_BYTES = PacketBytesDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] byte_value
    input  logic                   s_tuser,   // [0] packet_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] slot_echo, [13:8] entry_index, [21:14] stream_kind,
    // [34:22] es_pid, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic       queue_full;
    logic       queue_not_empty;
    logic       queue_pop;
    logic       entry_push;
    pmt_entry_t entry;
    pmt_entry_t queue_head;

    assign s_tready = !queue_full;

    pmt_parse_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_fire    (s_tvalid && s_tready),
        .byte_value   (s_tdata),
        .packet_start (s_tuser),
        .entry_push   (entry_push),
        .entry        (entry)
    );

    pmt_entry_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (entry_push),
        .push_data (entry),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    pmt_out_stage u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_head      (queue_head),
        .queue_pop       (queue_pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

endmodule

FILE: verif/tb_pmt_section_parser.sv
// Testbench for pmt_section_parser: builds transport packets carrying program map tables,
// streams them in byte by byte and checks every elementary-stream entry against a predictor.
// Depends on pmt_pkg and pmt_section_parser only.
`timescale 1ns / 1ps

module tb_pmt_section_parser;
    import pmt_pkg::*;

    localparam int PACKET_LEN     = PacketBytesDefault;
    localparam int LOOP_OFFSET    = 17;
    localparam int SECTION_FIXED  = 13;
    localparam int ENTRY_HEAD     = 5;
    localparam logic [7:0] SYNC   = 8'h47;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_PERCENT   = 26;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       packet_start;
    } ts_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;     // [7:0] byte_value
    logic                   s_tuser = 1'b0;   // [0] packet_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [7:0] slot_echo, [13:8] entry_index, [21:14] stream_kind,
    // [34:22] es_pid, [39:35] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    pmt_section_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ts_byte_t   byte_queue[$];
    pmt_entry_t pending_entries[$];
    ts_byte_t   offered;
    bit         driver_busy;

    int mismatch_count  = 0;
    int bytes_taken     = 0;
    int bytes_planned   = 0;
    int packets_built   = 0;
    int entries_checked = 0;
    int settings_used   = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int stall_cycles    = 0;
    logic quiet;

    // Both sides run without gaps for a stretch in the middle of the run.
    assign quiet = (bytes_taken >= 400) && (bytes_taken < 700);

    // Predictor state, mirroring the parser and its registers.
    logic [7:0]  pred_pos         = '0;
    bit          pred_in_table    = 1'b0;
    logic [4:0]  pred_pid_hi      = '0;
    logic [11:0] pred_sec_len     = '0;
    logic [11:0] pred_info_len    = '0;
    logic [13:0] pred_loop_left   = '0;
    logic [12:0] pred_entry_start = '0;
    logic [7:0]  pred_type        = '0;
    logic [12:0] pred_pid         = '0;
    logic [3:0]  pred_es_hi       = '0;
    logic [5:0]  pred_entry_num   = '0;
    logic [12:0] pred_target      = '0;
    logic [7:0]  pred_slot        = '0;

    task automatic report(input string field, input longint unsigned got,
                          input longint unsigned want);
        $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic parse_ts_byte(input ts_byte_t item);
        int         pos;
        int         step;
        bit         last;
        logic [7:0] b;
        pmt_entry_t e;
        b   = item.byte_value;
        pos = item.packet_start ? 0 : int'(pred_pos);
        if (pos >= PACKET_LEN)
            return;
        pred_pos = 8'(pos + 1);
        case (pos)
            0:
            begin
                pred_in_table    = (b == SYNC);
                pred_loop_left   = '0;
                pred_entry_start = '0;
                pred_entry_num   = '0;
            end
            1:  pred_pid_hi = b[4:0];
            2:  if ({pred_pid_hi, b} != pred_target) pred_in_table = 1'b0;
            6:  pred_sec_len = {b[3:0], 8'h00};
            7:  pred_sec_len = pred_sec_len | {4'h0, b};
            15: pred_info_len = {b[3:0], 8'h00};
            16:
            begin
                pred_info_len    = pred_info_len | {4'h0, b};
                pred_entry_start = 13'(LOOP_OFFSET + pred_info_len);
                if (pred_sec_len > SECTION_FIXED + pred_info_len)
                    pred_loop_left = 14'(pred_sec_len - SECTION_FIXED - pred_info_len);
                else
                    pred_loop_left = '0;
            end
            default: ;
        endcase
        if (!pred_in_table || pos < LOOP_OFFSET || pred_loop_left == 0 ||
            pos < pred_entry_start)
            return;
        case (pos - int'(pred_entry_start))
            0: pred_type = b;
            1: pred_pid = {b[4:0], 8'h00};
            2: pred_pid = pred_pid | {5'h00, b};
            3: pred_es_hi = b[3:0];
            4:
            begin
                step = ENTRY_HEAD + int'({pred_es_hi, b});
                last = (pred_loop_left <= step);
                e.slot_echo   = pred_slot;
                e.entry_index = pred_entry_num;
                e.stream_kind = pred_type;
                e.es_pid      = pred_pid;
                e.last_entry  = last;
                pending_entries.push_back(e);
                pred_loop_left   = last ? 14'd0 : 14'(pred_loop_left - step);
                pred_entry_start = 13'(pred_entry_start + step);
                pred_entry_num   = pred_entry_num + 6'd1;
            end
            default: ;
        endcase
    endtask

    task automatic check_entry(input logic [OUT_TDATA_W-1:0] data, input logic tlast);
        pmt_entry_t want;
        entries_checked++;
        if (pending_entries.size() == 0)
        begin
            report("entry with none pending", data, 0);
            return;
        end
        want = pending_entries.pop_front();
        if (data[7:0] != want.slot_echo)
            report("slot_echo", data[7:0], want.slot_echo);
        if (data[13:8] != want.entry_index)
            report("entry_index", data[13:8], want.entry_index);
        if (data[21:14] != want.stream_kind)
            report("stream_kind", data[21:14], want.stream_kind);
        if (data[34:22] != want.es_pid)
            report("es_pid", data[34:22], want.es_pid);
        if (tlast != want.last_entry)
            report("last_entry", tlast, want.last_entry);
        if (data[39:35] != '0)
            report("tdata padding", data[39:35], 0);
    endtask

    // Register writes land in the predictor at the same edge as in the block.
    always @(posedge clk)
    begin
        if (rst_n && cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TARGET_PID:   pred_target = cfg_data[12:0];
                CFG_PROGRAM_SLOT: pred_slot = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Byte driver: keeps an offered byte steady until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_ts_byte(offered);
                bytes_taken++;
                driver_busy = 1'b0;
            end
            else
            begin
                driver_busy = s_tvalid;
            end
            if (!driver_busy)
            begin
                if (byte_queue.size() != 0 &&
                    (quiet || $urandom_range(99, 0) >= IDLE_PERCENT))
                begin
                    offered = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.byte_value;
                    s_tuser  <= offered.packet_start;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Entry monitor, with one long hold-off so the entry queue fills and
    // back-pressure reaches the byte input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_entry(m_tdata, m_tlast);
            if (!hold_done && entries_checked == 20)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= quiet || ($urandom_range(99, 0) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("tb_pmt_section_parser: errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_table(input logic [12:0] pid, input logic [7:0] slot);
        logic [CFG_DATA_W-1:0] value;
        write_reg(CFG_TARGET_PID, pid);
        // Upper bits of the slot write are don't-care and get random values.
        value      = CFG_DATA_W'($urandom);
        value[7:0] = slot;
        write_reg(CFG_PROGRAM_SLOT, value);
        settings_used++;
    endtask

    // Waits until every byte is taken and every entry has come out, then lets
    // the output stage settle before registers may change.
    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_tvalid || pending_entries.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Builds one packet. A length of zero cuts it up to six bytes after the loop, within the packet length.
    task automatic add_packet(input bit sync_ok, input logic [12:0] pid,
                              input int info_bytes, input int entries, input int max_es,
                              input int slack, input int length, input bit mark_start,
                              input bit extreme);
        logic [7:0]  body[$];
        logic [7:0]  loop_bytes[$];
        logic [7:0]  b;
        logic [11:0] field12;
        logic [12:0] epid;
        int          sec;
        int          stop;
        ts_byte_t    item;
        for (int i = 0; i < entries; i++)
        begin
            field12 = extreme ? 12'd0 : 12'($urandom_range(max_es, 0));
            b = 8'($urandom);
            if (extreme) b = {8{i[0]}};
            loop_bytes.push_back(b);
            epid = 13'($urandom);
            if (extreme) epid = {13{i[0]}};
            b = 8'($urandom);
            if (extreme) b = {8{i[0]}};
            b[4:0] = epid[12:8];
            loop_bytes.push_back(b);
            loop_bytes.push_back(epid[7:0]);
            b = 8'($urandom);
            b[3:0] = field12[11:8];
            loop_bytes.push_back(b);
            loop_bytes.push_back(field12[7:0]);
            for (int k = 0; k < field12; k++)
            begin
                b = 8'($urandom);
                loop_bytes.push_back(b);
            end
        end
        sec = SECTION_FIXED + info_bytes + loop_bytes.size() + slack;
        if (sec < 0) sec = 0;
        if (sec > 4095) sec = 4095;

        b = 8'($urandom);
        if (sync_ok)
            b = SYNC;
        else
            while (b == SYNC) b = 8'($urandom);
        body.push_back(b);
        b = 8'($urandom);
        b[4:0] = pid[12:8];
        body.push_back(b);
        body.push_back(pid[7:0]);
        repeat (3)
        begin
            b = 8'($urandom);
            body.push_back(b);
        end
        field12 = 12'(sec);
        b = 8'($urandom);
        b[3:0] = field12[11:8];
        body.push_back(b);
        body.push_back(field12[7:0]);
        repeat (7)
        begin
            b = 8'($urandom);
            body.push_back(b);
        end
        field12 = 12'(info_bytes);
        b = 8'($urandom);
        b[3:0] = field12[11:8];
        body.push_back(b);
        body.push_back(field12[7:0]);
        for (int k = 0; k < info_bytes && k < PACKET_LEN; k++)
        begin
            b = 8'($urandom);
            body.push_back(b);
        end
        foreach (loop_bytes[k])
            body.push_back(loop_bytes[k]);

        stop = length;
        if (length == 0)
        begin
            stop = body.size() + $urandom_range(6, 0);
            if (stop > PACKET_LEN) stop = PACKET_LEN;
        end
        while (body.size() < stop)
        begin
            b = 8'($urandom);
            body.push_back(b);
        end
        for (int k = 0; k < stop; k++)
        begin
            item.byte_value   = body[k];
            item.packet_start = mark_start && (k == 0);
            byte_queue.push_back(item);
        end
        bytes_planned += stop;
        packets_built++;
    endtask

    initial
    begin
        logic [12:0] target;
        logic [7:0]  slot;
        ts_byte_t    item;
        int          random_bytes;
        int          phase_bytes;
        int          mark0;
        int          kind;
        int          info;
        int          n;
        int          es;
        int          slack;
        int          len;
        int          r;

        random_bytes = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Without any packet start after reset, the first byte is byte 0.
        set_table(13'h0000, 8'h5a);
        add_packet(1, 13'h0000, 0, 1, 0, 0, 0, 0, 1);
        wait_idle();

        set_table(13'h1fff, 8'hff);
        add_packet(1, 13'h1fff, 0, 4, 0, 0, 0, 1, 1);
        add_packet(0, 13'h1fff, 0, 2, 0, 0, 0, 1, 0);      // bad sync byte
        add_packet(1, 13'h0fff, 0, 2, 0, 0, 0, 1, 0);      // other PID
        add_packet(1, 13'h1fff, 5, 2, 0, -10, 0, 1, 0);    // section holds no loop
        // Fullest table, followed by bytes past the packet end.
        add_packet(1, 13'h1fff, 0, 34, 0, 0, PACKET_LEN + 6, 1, 0);
        // Entries that run past the packet end are dropped.
        add_packet(1, 13'h1fff, 150, 6, 0, 0, PACKET_LEN, 1, 0);
        // A new packet start in the middle of the second entry.
        add_packet(1, 13'h1fff, 0, 3, 0, 0, 24, 1, 0);
        add_packet(1, 13'h1fff, 3, 3, 40, 0, 0, 1, 0);     // long ES_info fields
        add_packet(1, 13'h1fff, 0, 3, 0, -3, 0, 1, 0);     // section ends inside an entry
        add_packet(1, 13'h1fff, 0, 2, 0, 8, 0, 1, 0);      // padding parsed as entries
        add_packet(1, 13'h1fff, 4095, 2, 0, 0, 24, 1, 0);
        wait_idle();

        set_table(13'h0000, 8'h00);
        add_packet(1, 13'h0000, 1, 2, 3, 0, 0, 1, 0);

        while (random_bytes < 60)
        begin
            wait_idle();
            target = 13'($urandom);
            slot   = 8'($urandom);
            r = $urandom_range(3, 0);
            if (r == 0) target = 13'h0000;
            if (r == 1) target = 13'h1fff;
            r = $urandom_range(3, 0);
            if (r == 0) slot = 8'h00;
            if (r == 1) slot = 8'hff;
            set_table(target, slot);

            phase_bytes = 0;
            while (phase_bytes < 60)
            begin
                mark0 = bytes_planned;
                kind  = $urandom_range(99, 0);
                info  = ($urandom_range(9, 0) == 0) ? $urandom_range(4095, 150)
                                                    : $urandom_range(12, 0);
                n     = $urandom_range(8, 1);
                es    = $urandom_range(1, 0) ? 0 : $urandom_range(20, 1);
                slack = 0;
                if ($urandom_range(3, 0) == 0)
                begin
                    slack = $urandom_range(12, 0);
                    slack = slack - 6;
                end
                r = $urandom_range(9, 0);
                if (r < 5)
                    len = 0;
                else if (r < 9)
                    len = PACKET_LEN;
                else
                    len = PACKET_LEN + $urandom_range(6, 1);

                if (kind < 70)
                begin
                    add_packet(1, target, info, n, es, slack, len, 1, 0);
                end
                else if (kind < 78)
                begin
                    add_packet(1, target ^ (13'd1 << $urandom_range(12, 0)),
                               info, n, es, slack, len, 1, 0);
                end
                else if (kind < 86)
                begin
                    add_packet(0, target, info, n, es, slack, len, 1, 0);
                end
                else if (kind < 94)
                begin
                    // Loose bytes, now and then with a stray packet start.
                    repeat ($urandom_range(40, 1))
                    begin
                        item.byte_value   = 8'($urandom);
                        item.packet_start = ($urandom_range(15, 0) == 0);
                        byte_queue.push_back(item);
                        bytes_planned++;
                    end
                end
                else
                begin
                    add_packet(1, target, info, n, es, slack, len, 0, 0);
                end
                phase_bytes += bytes_planned - mark0;
            end
            random_bytes += phase_bytes;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (pending_entries.size() != 0)
            report("entries never delivered", 0, pending_entries.size());

        $display("Streamed %0d bytes in %0d packets over %0d register settings.",
                 bytes_taken, packets_built, settings_used);
        $display("Compared %0d table entries, %0d mismatches.",
                 entries_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_pmt_section_parser: clean");
        else
            $display("tb_pmt_section_parser: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pmt_pkg.sv
hdl/pmt_parse_front.sv
hdl/pmt_entry_fifo.sv
hdl/pmt_out_stage.sv
hdl/pmt_section_parser.sv
verif/tb_pmt_section_parser.sv
